[hdl/utf8_decoder_with_byte_replacement_top_defines.svh]
// assertion macros for the utf8 decoder with byte replacement
// expects clk and rst_n in the scope of every use
`ifndef UTF8_DECODER_WITH_BYTE_REPLACEMENT_TOP_DEFINES_SVH
`define UTF8_DECODER_WITH_BYTE_REPLACEMENT_TOP_DEFINES_SVH

// checked only out of reset
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define UTF8D_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/utf8d_pkg.sv]
// shared types, constants and tables of the utf8 decoder
// no dependencies
`default_nettype none

package utf8d_pkg;

  localparam int MAX_SEQ_DEFAULT = 6;
  localparam int BYTE_W          = 8;
  localparam int CP_W            = 31;
  localparam int LEN_W           = 3;
  localparam int CONT_W          = 6;

  localparam logic [CP_W-1:0]   REPL_BASE = 31'h0000DC80;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;

  // lead byte classes
  localparam logic [1:0] LK_END   = 2'd0;
  localparam logic [1:0] LK_ASCII = 2'd1;
  localparam logic [1:0] LK_BAD   = 2'd2;
  localparam logic [1:0] LK_OPEN  = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  acc_init;
  } lead_info_t;

  function automatic logic [CP_W-1:0] overlong_limit(input logic [LEN_W-1:0] len);
    logic [CP_W-1:0] lim;
    case (len)
      3'd2:    lim = 31'h0000007F;
      3'd3:    lim = 31'h000007FF;
      3'd4:    lim = 31'h0000FFFF;
      3'd5:    lim = 31'h001FFFFF;
      3'd6:    lim = 31'h03FFFFFF;
      default: lim = '0;
    endcase
    return lim;
  endfunction

  function automatic logic [BYTE_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/utf8d_if.sv]
// valid/ready channels of the utf8 decoder: byte input and code point output
// depends on utf8d_pkg
`default_nettype none

interface utf8d_in_if;
  import utf8d_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_out_if;
  import utf8d_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_replacement;
  logic            end_of_string;
  logic            last;
  modport source (output valid, output code_point, output is_replacement,
                  output end_of_string, output last, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input end_of_string, input last, output ready);
endinterface

`default_nettype wire

[hdl/utf8d_lead_dec.sv]
// lead byte classifier: form length, class and initial accumulator bits
// depends on utf8d_pkg
`default_nettype none

module utf8d_lead_dec #(
  parameter int MAX_SEQUENCE_BYTES = utf8d_pkg::MAX_SEQ_DEFAULT
) (
  input  logic [utf8d_pkg::BYTE_W-1:0] lead_in,
  output utf8d_pkg::lead_info_t        info
);
  import utf8d_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEQUENCE_BYTES);

  logic [LEN_W-1:0] len;

  always_comb begin
    if ((lead_in & 8'hE0) == 8'hC0)      len = 3'd2;
    else if ((lead_in & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((lead_in & 8'hF8) == 8'hF0) len = 3'd4;
    else if ((lead_in & 8'hFC) == 8'hF8) len = 3'd5;
    else if ((lead_in & 8'hFE) == 8'hFC) len = 3'd6;
    else                                 len = 3'd0;
  end

  always_comb begin
    info.len      = len;
    info.acc_init = {{(CP_W-BYTE_W){1'b0}}, lead_in & lead_mask(len)};
    if (lead_in == '0) begin
      info.kind = LK_END;
    end else if (!lead_in[BYTE_W-1]) begin
      info.kind = LK_ASCII;
    end else if (len == '0 || len > MAX_LEN) begin
      info.kind = LK_BAD;
    end else begin
      info.kind = LK_OPEN;
    end
  end

endmodule

`default_nettype wire

[hdl/utf8_decoder_with_byte_replacement_top.sv]
// Streaming UTF-8 decoder for the 1 to 6 byte forms with per-byte replacement
// 0xDC80|byte on malformed input. One byte per transfer in, zero to six code
// point transfers out, the final one flagged by last. A continuation byte in
// the middle of a sequence is accepted in the idle state; a lead or ASCII byte
// is accepted, then classified in the lead state; the byte that completes a
// sequence is accepted, then overlong compare and emit happen in the same cycle;
// an error gives one result per cycle, while the output does not stall, out of
// the small sequencer that walks the held-byte file. Input ready is high only
// while the sequencer is idle.
// depends on utf8d_pkg, utf8d_if, utf8d_lead_dec and the defines header
`default_nettype none

module utf8_decoder_with_byte_replacement_top #(
  parameter int MAX_SEQUENCE_BYTES = utf8d_pkg::MAX_SEQ_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch
);
  import utf8d_pkg::*;

  `include "utf8_decoder_with_byte_replacement_top_defines.svh"

  localparam int HELD_DEPTH = MAX_SEQUENCE_BYTES - 2;
  localparam int HCW        = $clog2(HELD_DEPTH + 1);
  localparam int HIW        = $clog2(HELD_DEPTH);
  localparam logic [HCW-1:0] HELD_MAX = HCW'(HELD_DEPTH);
  localparam logic [HCW-1:0] HC_ONE   = HCW'(1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_FAIL   = 3'd2;
  localparam logic [2:0] ST_REPLAY = 3'd3;
  localparam logic [2:0] ST_LEAD   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] lead_r, lead_nxt;
  logic [HCW-1:0]    held_cnt_r, held_cnt_nxt;
  logic [HCW-1:0]    rep_idx_r, rep_idx_nxt;
  logic [CONT_W-1:0] held_r [HELD_DEPTH];
  logic              held_we;

  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;
  logic              out_rep_r, out_eos_r, out_last_r;

  logic              emit;
  logic [CP_W-1:0]   e_cp;
  logic              e_rep, e_eos, e_last;

  lead_info_t        lead_info;
  logic              in_xfer, slot_free, seq_open, lead_quiet, overlong;

  utf8d_lead_dec #(
    .MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
  ) u_lead_dec (
    .lead_in(byte_r),
    .info   (lead_info)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign seq_open    = (rem_r != '0) && (rem_r <= 3'd5);
  assign lead_quiet  = (lead_info.kind == LK_OPEN);
  assign overlong    = (acc_r <= overlong_limit(len_r));

  always_comb begin
    state_nxt    = state_r;
    byte_nxt     = byte_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    len_nxt      = len_r;
    lead_nxt     = lead_r;
    held_cnt_nxt = held_cnt_r;
    rep_idx_nxt  = rep_idx_r;
    held_we      = 1'b0;
    emit         = 1'b0;
    e_cp         = '0;
    e_rep        = 1'b0;
    e_eos        = 1'b0;
    e_last       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_nxt = in_ch.in_byte;
          if (!seq_open) begin
            rem_nxt   = '0;
            state_nxt = ST_LEAD;
          end else if ((in_ch.in_byte & CONT_MASK) == CONT_TAG) begin
            acc_nxt = {acc_r[CP_W-CONT_W-1:0], in_ch.in_byte[CONT_W-1:0]};
            rem_nxt = rem_r - 3'd1;
            if (rem_r == 3'd1) begin
              state_nxt = ST_CHECK;
            end else if (held_cnt_r < HELD_MAX) begin
              held_we      = 1'b1;
              held_cnt_nxt = held_cnt_r + HC_ONE;
            end
          end else begin
            state_nxt = ST_FAIL;
          end
        end
      end
      ST_CHECK: begin
        if (overlong) begin
          state_nxt = ST_FAIL;
        end else if (slot_free) begin
          emit         = 1'b1;
          e_cp         = acc_r;
          acc_nxt      = '0;
          rem_nxt      = '0;
          len_nxt      = '0;
          lead_nxt     = '0;
          held_cnt_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          emit        = 1'b1;
          e_cp        = REPL_BASE | {{(CP_W-BYTE_W){1'b0}}, lead_r};
          e_rep       = 1'b1;
          e_last      = (held_cnt_r == '0) && lead_quiet;
          rep_idx_nxt = '0;
          state_nxt   = (held_cnt_r == '0) ? ST_LEAD : ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (slot_free) begin
          emit        = 1'b1;
          e_cp        = REPL_BASE | {{(CP_W-BYTE_W){1'b0}}, CONT_TAG[BYTE_W-1:CONT_W],
                                     held_r[rep_idx_r[HIW-1:0]]};
          e_rep       = 1'b1;
          e_last      = (rep_idx_r == held_cnt_r - HC_ONE) && lead_quiet;
          rep_idx_nxt = rep_idx_r + HC_ONE;
          if (rep_idx_r == held_cnt_r - HC_ONE) begin
            state_nxt = ST_LEAD;
          end
        end
      end
      ST_LEAD: begin
        if (lead_info.kind == LK_OPEN) begin
          lead_nxt     = byte_r;
          len_nxt      = lead_info.len;
          rem_nxt      = lead_info.len - 3'd1;
          held_cnt_nxt = '0;
          acc_nxt      = lead_info.acc_init;
          state_nxt    = ST_IDLE;
        end else if (slot_free) begin
          emit         = 1'b1;
          acc_nxt      = '0;
          rem_nxt      = '0;
          len_nxt      = '0;
          lead_nxt     = '0;
          held_cnt_nxt = '0;
          state_nxt    = ST_IDLE;
          case (lead_info.kind)
            LK_END: begin
              e_eos = 1'b1;
            end
            LK_ASCII: begin
              e_cp = {{(CP_W-BYTE_W){1'b0}}, byte_r};
            end
            default: begin
              e_cp  = REPL_BASE | {{(CP_W-BYTE_W){1'b0}}, byte_r};
              e_rep = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      rem_r       <= '0;
      len_r       <= '0;
      lead_r      <= '0;
      held_cnt_r  <= '0;
      rep_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_r      <= acc_nxt;
      rem_r      <= rem_nxt;
      len_r      <= len_nxt;
      lead_r     <= lead_nxt;
      held_cnt_r <= held_cnt_nxt;
      rep_idx_r  <= rep_idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (held_we) begin
      held_r[held_cnt_r[HIW-1:0]] <= in_ch.in_byte[CONT_W-1:0];
    end
    if (emit) begin
      out_cp_r   <= e_cp;
      out_rep_r  <= e_rep;
      out_eos_r  <= e_eos;
      out_last_r <= e_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.code_point     = out_cp_r;
  assign out_ch.is_replacement = out_rep_r;
  assign out_ch.end_of_string  = out_eos_r;
  assign out_ch.last           = out_last_r;

  `UTF8D_ASSERT(a_more_pending, out_valid_r && !out_last_r |-> state_r != ST_IDLE,
                "non-last result with idle sequencer")
  `UTF8D_ASSERT(a_repl_range,
                out_valid_r && out_rep_r |-> out_cp_r[CP_W-1:7] == REPL_BASE[CP_W-1:7],
                "replacement outside 0xDC80..0xDCFF")
  `UTF8D_ASSERT(a_held_bound, held_cnt_r <= HELD_MAX, "held byte count overflow")
  `UTF8D_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid_r && state_r == ST_IDLE,
                    "output valid after reset")

endmodule

`default_nettype wire
